@@ design/smlp_pkg.sv @@
// Shared types and constants for the cyclic-linked sparse matrix packer.
package smlp_pkg;

    localparam int MAX_ROWS    = 64;
    localparam int MAX_COLS    = 64;
    localparam int MAX_ENTRIES = 1024;

    // Row and column numbers share one width; the line tables are sized by it.
    localparam int LINE_W     = 6;
    localparam int LINE_DEPTH = 2 ** LINE_W;
    localparam int USED_W     = 7;
    localparam int IDX_W      = 10;
    localparam int CNT_W      = 11;
    localparam int VAL_W      = 32;

    // A normal element gives at most three results.
    localparam int NRES   = 3;
    localparam int RCNT_W = 2;

    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS_USED = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS_USED = 1'b1;

    localparam logic CMD_ELEMENT = 1'b0;
    localparam logic CMD_CLEAR   = 1'b1;

    typedef enum logic [2:0] {
        K_ENTRY     = 3'd0,
        K_ROW_PATCH = 3'd1,
        K_COL_PATCH = 3'd2,
        K_ROW_HEAD  = 3'd3,
        K_COL_HEAD  = 3'd4,
        K_RANGE_ERR = 3'd5,
        K_FULL      = 3'd6
    } t_kind;

    typedef struct packed {
        logic                    command;
        logic [LINE_W-1:0]       row;
        logic [LINE_W-1:0]       col;
        logic signed [VAL_W-1:0] value;
    } t_item;

    typedef struct packed {
        t_kind                   kind;
        logic [IDX_W-1:0]        index;
        logic signed [VAL_W-1:0] value;
        logic [IDX_W-1:0]        row_link;
        logic [IDX_W-1:0]        col_link;
        logic                    last;
    } t_res;

    // Table updates caused by one processed item.
    typedef struct packed {
        logic             clear;
        logic             wr_en;
        logic             row_new;
        logic             col_new;
        logic [IDX_W-1:0] idx;
    } t_upd;

endpackage

@@ design/smlp_lines.sv @@
// Per-line (row or column) started flags, head and tail entry tables.
module smlp_lines
    import smlp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_clear,
    input  logic              i_rd_en,
    input  logic [LINE_W-1:0] i_rd_addr,
    input  logic [LINE_W-1:0] i_lk_addr,
    input  logic              i_wr_en,
    input  logic              i_wr_head,
    input  logic [IDX_W-1:0]  i_wr_idx,
    output logic              o_started,
    output logic [IDX_W-1:0]  o_head,
    output logic [IDX_W-1:0]  o_tail
);

    logic [LINE_DEPTH-1:0] r_started;
    logic [IDX_W-1:0]      r_head_mem [LINE_DEPTH];
    logic [IDX_W-1:0]      r_tail_mem [LINE_DEPTH];
    logic [IDX_W-1:0]      r_head;
    logic [IDX_W-1:0]      r_tail;
    logic                  w_hit;

    assign o_started = r_started[i_lk_addr];
    assign o_head    = r_head;
    assign o_tail    = r_tail;

    // Write and read of the same line in the same cycle: forward the new index.
    assign w_hit = i_wr_en && (i_lk_addr == i_rd_addr);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_started <= '0;
        end else if (i_clear) begin
            r_started <= '0;
        end else if (i_wr_en && i_wr_head) begin
            r_started[i_lk_addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_tail_mem[i_lk_addr] <= i_wr_idx;
            if (i_wr_head) begin
                r_head_mem[i_lk_addr] <= i_wr_idx;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_tail <= w_hit ? i_wr_idx : r_tail_mem[i_rd_addr];
            r_head <= (w_hit && i_wr_head) ? i_wr_idx : r_head_mem[i_rd_addr];
        end
    end

endmodule

@@ design/smlp_core.sv @@
// Element decode: checks, entry allocation and the three link results.
module smlp_core
    import smlp_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_fire,
    input  t_item                  i_item,
    input  logic [USED_W-1:0]      i_rows_used,
    input  logic [USED_W-1:0]      i_cols_used,
    input  logic                   i_row_started,
    input  logic [IDX_W-1:0]       i_row_head,
    input  logic [IDX_W-1:0]       i_row_tail,
    input  logic                   i_col_started,
    input  logic [IDX_W-1:0]       i_col_head,
    input  logic [IDX_W-1:0]       i_col_tail,
    output t_res [NRES-1:0]        o_res,
    output logic [RCNT_W-1:0]      o_res_cnt,
    output t_upd                   o_upd
);

    logic [CNT_W-1:0]  r_entry_cnt;
    logic [USED_W-1:0] w_row_x;
    logic [USED_W-1:0] w_col_x;
    logic              w_range_err;
    logic              w_zero;
    logic              w_full;
    logic              w_normal;
    logic [IDX_W-1:0]  w_idx;

    assign w_row_x = USED_W'(i_item.row);
    assign w_col_x = USED_W'(i_item.col);

    assign w_range_err = (w_row_x >= i_rows_used) || (w_row_x >= USED_W'(MAX_ROWS)) ||
                         (w_col_x >= i_cols_used) || (w_col_x >= USED_W'(MAX_COLS));
    assign w_zero   = (i_item.value == '0);
    assign w_full   = (r_entry_cnt >= CNT_W'(MAX_ENTRIES));
    assign w_idx    = r_entry_cnt[IDX_W-1:0];
    assign w_normal = (i_item.command == CMD_ELEMENT) && !w_range_err && !w_zero && !w_full;

    always_comb begin
        o_res     = '0;
        o_res_cnt = '0;
        priority if (i_item.command == CMD_CLEAR) begin
            o_res_cnt = '0;
        end else if (w_range_err) begin
            o_res[0].kind = K_RANGE_ERR;
            o_res[0].last = 1'b1;
            o_res_cnt     = RCNT_W'(1);
        end else if (w_zero) begin
            o_res_cnt = '0;
        end else if (w_full) begin
            o_res[0].kind = K_FULL;
            o_res[0].last = 1'b1;
            o_res_cnt     = RCNT_W'(1);
        end else begin
            // New entry closes its row and column cycles back to the heads.
            o_res[0].kind     = K_ENTRY;
            o_res[0].index    = w_idx;
            o_res[0].value    = i_item.value;
            o_res[0].row_link = i_row_started ? i_row_head : w_idx;
            o_res[0].col_link = i_col_started ? i_col_head : w_idx;

            o_res[1].kind     = i_row_started ? K_ROW_PATCH : K_ROW_HEAD;
            o_res[1].index    = i_row_started ? i_row_tail : IDX_W'(i_item.row);
            o_res[1].row_link = w_idx;

            o_res[2].kind     = i_col_started ? K_COL_PATCH : K_COL_HEAD;
            o_res[2].index    = i_col_started ? i_col_tail : IDX_W'(i_item.col);
            o_res[2].col_link = w_idx;
            o_res[2].last     = 1'b1;
            o_res_cnt         = RCNT_W'(NRES);
        end
    end

    assign o_upd.clear   = i_fire && (i_item.command == CMD_CLEAR);
    assign o_upd.wr_en   = i_fire && w_normal;
    assign o_upd.row_new = !i_row_started;
    assign o_upd.col_new = !i_col_started;
    assign o_upd.idx     = w_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry_cnt <= '0;
        end else if (o_upd.clear) begin
            r_entry_cnt <= '0;
        end else if (o_upd.wr_en) begin
            r_entry_cnt <= r_entry_cnt + CNT_W'(1);
        end
    end

endmodule

@@ design/smlp_outq.sv @@
// Result queue: holds up to three results and presents one per cycle while not stalled.
module smlp_outq
    import smlp_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_load,
    input  logic [RCNT_W-1:0]  i_load_cnt,
    input  t_res [NRES-1:0]    i_load_res,
    input  logic               i_stall,
    output logic               o_valid,
    output t_res               o_res,
    output logic               o_free
);

    t_res [NRES-1:0]    r_slot;
    logic [RCNT_W-1:0]  r_cnt;
    logic [RCNT_W-1:0]  n_cnt;
    logic               w_take;

    assign o_valid = (r_cnt != '0);
    assign o_res   = r_slot[0];
    assign w_take  = o_valid && !i_stall;
    // Free when empty, or once the last held result leaves this cycle.
    assign o_free  = (r_cnt == '0) || ((r_cnt == RCNT_W'(1)) && w_take);

    always_comb begin
        n_cnt = r_cnt;
        if (i_load) begin
            n_cnt = i_load_cnt;
        end else if (w_take) begin
            n_cnt = r_cnt - RCNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_slot <= i_load_res;
        end else if (w_take) begin
            // advance the queue by one slot
            for (int i = 0; i < NRES - 1; i++) begin
                r_slot[i] <= r_slot[i+1];
            end
        end
    end

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> ((r_cnt == '0) || ((r_cnt == RCNT_W'(1)) && !i_stall)))
        else $error("result queue loaded while results still pending");

    a_last_is_tail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_res.last) |-> (r_cnt == RCNT_W'(1)))
        else $error("final result shown with more results queued");

    a_entry_leads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_res.kind == K_ENTRY)) |-> ((r_cnt == RCNT_W'(NRES)) && !o_res.last))
        else $error("new entry result not at the head of a full group");

    a_group_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_take && (r_cnt > RCNT_W'(1)) && !i_load) |=> o_valid)
        else $error("result group broken off");

endmodule

@@ design/sparse_matrix_linked_pack.sv @@
// Top level of the cyclic-linked sparse matrix packer.
//
//  channel  | direction | handshake            | payload
//  ---------+-----------+----------------------+---------------------------------------
//  element  | in        | i_valid / o_stall    | i_command i_row i_col i_value
//  result   | out       | o_valid / i_stall    | o_kind o_index o_value_res o_row_link
//           |           |                      | o_col_link o_last
//  config   | in        | i_cfg_we             | i_cfg_index i_cfg_data
//
// A nonzero in-range element gives three results, one per cycle when not stalled;
// range errors and table-full give one result; clear commands and in-range zero values
// give no result and pass through the input register. The result port sets the rate.
// The line tables are read when an item is taken and written when it is processed.
// Synchronous reset clears started flags, entry count, queue and config (64 rows/cols).
// A stall on the result side holds the queue; o_stall rises once the input register waits.
module sparse_matrix_linked_pack
    import smlp_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic                    i_command,
    input  logic [LINE_W-1:0]       i_row,
    input  logic [LINE_W-1:0]       i_col,
    input  logic signed [VAL_W-1:0] i_value,
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic [2:0]              o_kind,
    output logic [IDX_W-1:0]        o_index,
    output logic signed [VAL_W-1:0] o_value_res,
    output logic [IDX_W-1:0]        o_row_link,
    output logic [IDX_W-1:0]        o_col_link,
    output logic                    o_last,
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [USED_W-1:0]       i_cfg_data
);

    logic [USED_W-1:0]  r_rows_used;
    logic [USED_W-1:0]  r_cols_used;
    t_item              r_item;
    logic               r_in_valid;
    logic               w_in_acc;
    logic               w_free;
    logic               w_fire;
    t_res [NRES-1:0]    w_res;
    logic [RCNT_W-1:0]  w_res_cnt;
    t_upd               w_upd;
    t_res               w_out;
    logic               w_row_started;
    logic [IDX_W-1:0]   w_row_head;
    logic [IDX_W-1:0]   w_row_tail;
    logic               w_col_started;
    logic [IDX_W-1:0]   w_col_head;
    logic [IDX_W-1:0]   w_col_tail;

    assign w_fire   = r_in_valid && w_free;
    assign o_stall  = r_in_valid && !w_free;
    assign w_in_acc = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows_used <= USED_W'(MAX_ROWS);
            r_cols_used <= USED_W'(MAX_COLS);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_ROWS_USED: r_rows_used <= i_cfg_data;
                CFG_COLS_USED: r_cols_used <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_acc) begin
            r_in_valid <= 1'b1;
        end else if (w_fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_item.command <= i_command;
            r_item.row     <= i_row;
            r_item.col     <= i_col;
            r_item.value   <= i_value;
        end
    end

    smlp_lines u_rows (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_clear   (w_upd.clear),
        .i_rd_en   (w_in_acc),
        .i_rd_addr (i_row),
        .i_lk_addr (r_item.row),
        .i_wr_en   (w_upd.wr_en),
        .i_wr_head (w_upd.row_new),
        .i_wr_idx  (w_upd.idx),
        .o_started (w_row_started),
        .o_head    (w_row_head),
        .o_tail    (w_row_tail)
    );

    smlp_lines u_cols (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_clear   (w_upd.clear),
        .i_rd_en   (w_in_acc),
        .i_rd_addr (i_col),
        .i_lk_addr (r_item.col),
        .i_wr_en   (w_upd.wr_en),
        .i_wr_head (w_upd.col_new),
        .i_wr_idx  (w_upd.idx),
        .o_started (w_col_started),
        .o_head    (w_col_head),
        .o_tail    (w_col_tail)
    );

    smlp_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_fire        (w_fire),
        .i_item        (r_item),
        .i_rows_used   (r_rows_used),
        .i_cols_used   (r_cols_used),
        .i_row_started (w_row_started),
        .i_row_head    (w_row_head),
        .i_row_tail    (w_row_tail),
        .i_col_started (w_col_started),
        .i_col_head    (w_col_head),
        .i_col_tail    (w_col_tail),
        .o_res         (w_res),
        .o_res_cnt     (w_res_cnt),
        .o_upd         (w_upd)
    );

    smlp_outq u_outq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (w_fire),
        .i_load_cnt (w_res_cnt),
        .i_load_res (w_res),
        .i_stall    (i_stall),
        .o_valid    (o_valid),
        .o_res      (w_out),
        .o_free     (w_free)
    );

    assign o_kind      = w_out.kind;
    assign o_index     = w_out.index;
    assign o_value_res = w_out.value;
    assign o_row_link  = w_out.row_link;
    assign o_col_link  = w_out.col_link;
    assign o_last      = w_out.last;

endmodule

@@ tb/tb_sparse_matrix_linked_pack.sv @@
// Testbench for the cyclic-linked sparse matrix packer: random and directed items, scoreboard.
module tb_sparse_matrix_linked_pack
    import smlp_pkg::*;
();

    localparam int CYCLE_LIMIT = 600000;
    localparam int HOLD_CYCLES = 400;
    localparam int DRAIN_CYCLES = 12;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_valid = 1'b0;
    logic                    o_stall;
    logic                    i_command = CMD_ELEMENT;
    logic [LINE_W-1:0]       i_row = '0;
    logic [LINE_W-1:0]       i_col = '0;
    logic signed [VAL_W-1:0] i_value = '0;
    logic                    o_valid;
    logic                    i_stall = 1'b0;
    logic [2:0]              o_kind;
    logic [IDX_W-1:0]        o_index;
    logic signed [VAL_W-1:0] o_value_res;
    logic [IDX_W-1:0]        o_row_link;
    logic [IDX_W-1:0]        o_col_link;
    logic                    o_last;
    logic                    i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]    i_cfg_index = CFG_ROWS_USED;
    logic [USED_W-1:0]       i_cfg_data = '0;

    sparse_matrix_linked_pack uut (.*);

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Tracks the row and column cycles and holds the link results still owed.
    class link_board;
        logic [USED_W-1:0] rows_used;
        logic [USED_W-1:0] cols_used;
        bit                row_started [MAX_ROWS];
        logic [IDX_W-1:0]  row_head [MAX_ROWS];
        logic [IDX_W-1:0]  row_tail [MAX_ROWS];
        bit                col_started [MAX_COLS];
        logic [IDX_W-1:0]  col_head [MAX_COLS];
        logic [IDX_W-1:0]  col_tail [MAX_COLS];
        int                entry_count;
        t_res              owed_links [$];
        int                errors;

        function new();
            rows_used = USED_W'(MAX_ROWS);
            cols_used = USED_W'(MAX_COLS);
            errors = 0;
            clear_store();
        endfunction

        function void clear_store();
            foreach (row_started[r]) row_started[r] = 1'b0;
            foreach (col_started[c]) col_started[c] = 1'b0;
            entry_count = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [USED_W-1:0] data);
            if (idx == CFG_ROWS_USED) rows_used = data;
            else if (idx == CFG_COLS_USED) cols_used = data;
        endfunction

        function void owe(t_kind kind, logic [IDX_W-1:0] index, logic signed [VAL_W-1:0] value,
                          logic [IDX_W-1:0] rlink, logic [IDX_W-1:0] clink, logic last);
            t_res r;
            r.kind = kind;
            r.index = index;
            r.value = value;
            r.row_link = rlink;
            r.col_link = clink;
            r.last = last;
            owed_links = {owed_links, r};
        endfunction

        function void take_element(logic cmd, logic [LINE_W-1:0] row, logic [LINE_W-1:0] col,
                                   logic signed [VAL_W-1:0] val);
            logic [IDX_W-1:0] slot;
            if (cmd == CMD_CLEAR) begin
                clear_store();
                return;
            end
            // range check wins over the zero check
            if (row >= rows_used || col >= cols_used) begin
                owe(K_RANGE_ERR, '0, '0, '0, '0, 1'b1);
                return;
            end
            if (val == 0) return;
            if (entry_count >= MAX_ENTRIES) begin
                owe(K_FULL, '0, '0, '0, '0, 1'b1);
                return;
            end
            slot = IDX_W'(entry_count);
            owe(K_ENTRY, slot, val, row_started[row] ? row_head[row] : slot,
                col_started[col] ? col_head[col] : slot, 1'b0);
            if (row_started[row]) begin
                owe(K_ROW_PATCH, row_tail[row], '0, slot, '0, 1'b0);
            end else begin
                owe(K_ROW_HEAD, IDX_W'(row), '0, slot, '0, 1'b0);
                row_started[row] = 1'b1;
                row_head[row] = slot;
            end
            row_tail[row] = slot;
            if (col_started[col]) begin
                owe(K_COL_PATCH, col_tail[col], '0, '0, slot, 1'b1);
            end else begin
                owe(K_COL_HEAD, IDX_W'(col), '0, '0, slot, 1'b1);
                col_started[col] = 1'b1;
                col_head[col] = slot;
            end
            col_tail[col] = slot;
            entry_count++;
        endfunction

        function bit field_ok(string field, logic signed [VAL_W:0] want,
                              logic signed [VAL_W:0] got);
            if (got === want) return 1'b1;
            $error("%s: expected %0d, got %0d", field, want, got);
            return 1'b0;
        endfunction

        function void check_result(t_res got);
            t_res want;
            bit ok;
            if (owed_links.size() == 0) begin
                $error("result with nothing expected: kind %0d index %0d",
                       got.kind, got.index);
                errors++;
                return;
            end
            want = owed_links.pop_front();
            ok = field_ok("kind", 33'(want.kind), 33'(got.kind));
            ok &= field_ok("index", 33'(want.index), 33'(got.index));
            ok &= field_ok("value_res", 33'(want.value), 33'(got.value));
            ok &= field_ok("row_link", 33'(want.row_link), 33'(got.row_link));
            ok &= field_ok("col_link", 33'(want.col_link), 33'(got.col_link));
            ok &= field_ok("last", 33'(want.last), 33'(got.last));
            if (!ok) errors++;
        endfunction

        function int pending();
            return owed_links.size();
        endfunction
    endclass

    link_board board = new();
    bit        hold_req = 1'b0;
    int        span_left [2] = '{0, 0};
    int        span_mode [2] = '{0, 0};
    int        cycle_count = 0;

    // Idle in stretches: none, short or full-range gaps, redrawn every 8 to 30 items.
    function automatic int pick_gap(int side);
        if (span_left[side] == 0) begin
            span_left[side] = $urandom_range(8, 30);
            span_mode[side] = $urandom_range(0, 2);
        end
        span_left[side]--;
        if (span_mode[side] == 0) return 0;
        if (span_mode[side] == 1) return $urandom_range(0, 3);
        return $urandom_range(0, 17);
    endfunction

    function automatic logic [LINE_W-1:0] pick_line(int lim);
        int p;
        p = $urandom_range(0, 9);
        if (lim == 0 || p < 2) return LINE_W'($urandom_range(0, 63));
        if (p < 6) return LINE_W'($urandom_range(0, (lim < 4 ? lim : 4) - 1));
        return LINE_W'($urandom_range(0, lim - 1));
    endfunction

    function automatic logic signed [VAL_W-1:0] pick_value(bit nonzero);
        int p;
        logic signed [VAL_W-1:0] v;
        p = $urandom_range(0, 19);
        if (p < 2 && !nonzero) return '0;
        if (p < 4) begin
            case ($urandom_range(0, 3))
                0: return 32'sh7FFF_FFFF;
                1: return 32'sh8000_0000;
                2: return -32'sd1;
                default: return 32'sd1;
            endcase
        end
        do v = $urandom; while (v == 0);
        return v;
    endfunction

    task automatic send_element(input logic cmd, input logic [LINE_W-1:0] row,
                                input logic [LINE_W-1:0] col,
                                input logic signed [VAL_W-1:0] val);
        int gap;
        gap = pick_gap(0);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_command <= cmd;
        i_row <= row;
        i_col <= col;
        i_value <= val;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        board.take_element(cmd, row, col, val);
    endtask

    // Drop valid, wait out every owed result, then let zero items and clears pass too.
    task automatic settle();
        i_valid <= 1'b0;
        while (board.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [USED_W-1:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        board.write_reg(idx, data);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_lines(input logic [USED_W-1:0] rows, input logic [USED_W-1:0] cols);
        write_reg(CFG_ROWS_USED, rows);
        write_reg(CFG_COLS_USED, cols);
    endtask

    task automatic random_phase(input int count);
        int rlim;
        int clim;
        logic cmd;
        rlim = (board.rows_used > MAX_ROWS) ? MAX_ROWS : board.rows_used;
        clim = (board.cols_used > MAX_COLS) ? MAX_COLS : board.cols_used;
        repeat (count) begin
            cmd = ($urandom_range(0, 99) < 3) ? CMD_CLEAR : CMD_ELEMENT;
            send_element(cmd, pick_line(rlim), pick_line(clim), pick_value(1'b0));
        end
    endtask

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    initial begin : result_side
        int gap;
        t_res got;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            gap = pick_gap(1);
            // long hold so the block backs up into its input
            if (hold_req) begin
                hold_req = 1'b0;
                gap = HOLD_CYCLES;
            end
            if (gap > 0) begin
                i_stall <= 1'b1;
                repeat (gap) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            do @(posedge i_clk); while (!o_valid);
            got.kind = t_kind'(o_kind);
            got.index = o_index;
            got.value = o_value_res;
            got.row_link = o_row_link;
            got.col_link = o_col_link;
            got.last = o_last;
            board.check_result(got);
        end
    end

    initial begin : element_side
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // heads, patches and value extremes at the corners of a full-size matrix
        send_element(CMD_ELEMENT, 6'd0, 6'd0, 32'sh7FFF_FFFF);
        send_element(CMD_ELEMENT, 6'd0, 6'd63, 32'sh8000_0000);
        send_element(CMD_ELEMENT, 6'd63, 6'd0, -32'sd1);
        send_element(CMD_ELEMENT, 6'd63, 6'd63, 32'sd1);
        send_element(CMD_ELEMENT, 6'd0, 6'd0, 32'sd0);
        send_element(CMD_ELEMENT, 6'd0, 6'd0, 32'sd5);
        send_element(CMD_ELEMENT, 6'd42, 6'd21, pick_value(1'b1));
        send_element(CMD_CLEAR, 6'd63, 6'd63, pick_value(1'b1));
        send_element(CMD_ELEMENT, 6'd63, 6'd63, 32'sh5555_5555);
        send_element(CMD_ELEMENT, 6'd0, 6'd0, 32'shAAAA_AAAA);
        settle();

        // one row: out-of-range row, even with a zero value
        set_lines(7'd1, 7'd64);
        send_element(CMD_ELEMENT, 6'd1, 6'd0, 32'sd7);
        send_element(CMD_ELEMENT, 6'd63, 6'd5, 32'sd0);
        send_element(CMD_ELEMENT, 6'd0, 6'd63, -32'sd2);
        send_element(CMD_ELEMENT, 6'd0, 6'd5, 32'sd0);
        settle();

        // no rows at all, columns past the table depth
        set_lines(7'd0, 7'd127);
        send_element(CMD_ELEMENT, 6'd0, 6'd0, 32'sd1);
        send_element(CMD_ELEMENT, 6'd0, 6'd63, 32'sd0);
        settle();

        set_lines(7'd127, 7'd1);
        send_element(CMD_ELEMENT, 6'd63, 6'd1, 32'sd3);
        send_element(CMD_ELEMENT, 6'd63, 6'd0, 32'sd3);
        settle();

        set_lines(7'd64, 7'd64);
        hold_req = 1'b1;
        random_phase(40);
        settle();
        set_lines(7'd3, 7'd5);
        random_phase(40);
        settle();
        set_lines(7'd127, 7'd127);
        random_phase(40);
        settle();
        set_lines(7'd20, 7'd1);
        random_phase(40);
        settle();
        set_lines(7'd1, 7'd40);
        random_phase(40);
        settle();
        set_lines(7'd64, 7'd7);
        random_phase(40);
        settle();

        set_lines(7'd2, 7'd64);
        send_element(CMD_ELEMENT, 6'd5, 6'd0, 32'sd9);
        send_element(CMD_ELEMENT, 6'd1, 6'd1, 32'sd9);
        send_element(CMD_CLEAR, 6'd0, 6'd0, 32'sd0);
        send_element(CMD_ELEMENT, 6'd1, 6'd63, 32'sd77);
        settle();
        repeat (20) @(posedge i_clk);

        if (board.errors == 0 && board.pending() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
